@@ rtl/core/olps_pkg.sv @@
package olps_pkg;

    // Default capacity of the list.
    localparam int DEPTH_DEF = 16;

    // Field widths fixed by the word formats.
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    // Command word taken in.
    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    // Result word handed out.
    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic                    found;
        logic signed [VAL_W-1:0] removed_value;
        logic [COUNT_W-1:0]      entry_count;
    } t_out_word;

    // Operation wave that travels down the row of cells, one cell a cycle.
    typedef struct packed {
        logic             act;
        logic [CMD_W-1:0] cmd;
        logic [VAL_W-1:0] key;
        logic             hit;
        logic [VAL_W-1:0] carry;
    } t_wave;

endpackage

@@ rtl/core/olps_stream_if.sv @@
interface olps_stream_if #(
    parameter type t_data = logic
);

    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/core/olps_cell.sv @@
module olps_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  olps_pkg::t_wave           i_wave,
    input  logic [CW-1:0]             i_count,
    input  logic [olps_pkg::VAL_W-1:0] i_next_entry,
    output olps_pkg::t_wave           o_wave,
    output logic [olps_pkg::VAL_W-1:0] o_entry
);

    logic [olps_pkg::VAL_W-1:0] r_entry;
    logic [olps_pkg::VAL_W-1:0] n_entry;
    olps_pkg::t_wave            r_wave;
    olps_pkg::t_wave            n_wave;
    logic                       w_in_range;
    logic                       w_match;

    // An insert also writes the first free place; other commands touch held entries only.
    assign w_in_range = (i_wave.cmd == olps_pkg::CMD_INSERT) ? (CW'(IDX) <= i_count)
                                                             : (CW'(IDX) < i_count);
    assign w_match    = (r_entry == i_wave.key);

    // Work of the cell as the wave passes through it.
    always_comb begin
        n_wave  = i_wave;
        n_entry = r_entry;
        if (i_wave.act && w_in_range) begin
            case (i_wave.cmd)
                olps_pkg::CMD_INSERT: begin
                    n_entry      = i_wave.carry;
                    n_wave.carry = r_entry;
                end
                olps_pkg::CMD_DELETE, olps_pkg::CMD_REMOVE: begin
                    if (i_wave.hit) begin
                        n_entry = i_next_entry;
                    end else if ((i_wave.cmd == olps_pkg::CMD_DELETE) || w_match) begin
                        n_wave.hit   = 1'b1;
                        n_wave.carry = r_entry;
                        n_entry      = i_next_entry;
                    end
                end
                olps_pkg::CMD_SEARCH: begin
                    if (w_match) begin
                        n_wave.hit = 1'b1;
                    end
                end
                default: begin
                    n_wave = i_wave;
                end
            endcase
        end
    end

    // The entry itself needs no reset; only the wave's activity flag does.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_wave.act <= 1'b0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave  = r_wave;
    assign o_entry = r_entry;

endmodule

@@ rtl/core/ordered_list_push_pop_search_remove_unit.sv @@
// Ordered list of signed words, front first, held in a row of DEPTH cells.
// A command that meets a full or empty list gives its result word without sending a wave.
// Any other command sends a wave down the row, one cell a cycle, and its result word is
// made when the wave leaves the last cell; the next command is taken once that result word
// has been loaded into the output register, so commands never overlap.
// Reset (synchronous, active low) empties the list and drops any pending word.
module ordered_list_push_pop_search_remove_unit #(
    parameter int DEPTH = olps_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    olps_stream_if.sink         i_in,
    olps_stream_if.source       o_out
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    olps_pkg::t_wave     r_inj;
    olps_pkg::t_wave     n_inj;
    olps_pkg::t_out_word r_pend;
    olps_pkg::t_out_word n_pend;
    olps_pkg::t_out_word r_out;
    olps_pkg::t_out_word n_out;
    logic                r_out_valid;
    logic                n_out_valid;

    olps_pkg::t_wave             w_wave  [DEPTH+1];
    logic [olps_pkg::VAL_W-1:0]  w_entry [DEPTH];
    logic [olps_pkg::VAL_W-1:0]  w_next  [DEPTH];
    olps_pkg::t_wave             w_last;
    logic                        w_in_acc;
    olps_pkg::t_in_word          w_in;

    // Row of cells; each one shifts from its right-hand neighbour when closing a gap.
    assign w_wave[0] = r_inj;
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == DEPTH - 1) begin : g_tail
                assign w_next[g] = '0;
            end else begin : g_body
                assign w_next[g] = w_entry[g+1];
            end
            olps_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_wave       (w_wave[g]),
                .i_count      (r_count),
                .i_next_entry (w_next[g]),
                .o_wave       (w_wave[g+1]),
                .o_entry      (w_entry[g])
            );
        end
    endgenerate

    assign w_last   = w_wave[DEPTH];
    assign w_in     = i_in.data;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc = i_in.valid && (r_state == S_IDLE);

    // Sequencing of one command and the result word.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_inj       = r_inj;
        n_inj.act   = 1'b0;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_pend.status        = olps_pkg::STAT_OK;
                    n_pend.found         = 1'b0;
                    n_pend.removed_value = '0;
                    n_pend.entry_count   = olps_pkg::COUNT_W'(r_count);
                    if ((w_in.command == olps_pkg::CMD_INSERT) && (r_count == CW'(DEPTH))) begin
                        n_pend.status = olps_pkg::STAT_FULL;
                        n_state       = S_HOLD;
                    end else if ((w_in.command != olps_pkg::CMD_INSERT) && (r_count == '0)) begin
                        n_pend.status = olps_pkg::STAT_EMPTY;
                        n_state       = S_HOLD;
                    end else begin
                        n_inj.act   = 1'b1;
                        n_inj.cmd   = w_in.command;
                        n_inj.key   = w_in.value;
                        n_inj.hit   = 1'b0;
                        n_inj.carry = w_in.value;
                        n_state     = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (w_last.act) begin
                    n_pend.status        = olps_pkg::STAT_OK;
                    n_pend.found         = 1'b0;
                    n_pend.removed_value = '0;
                    case (w_last.cmd)
                        olps_pkg::CMD_INSERT: begin
                            n_count = r_count + CW'(1);
                        end
                        olps_pkg::CMD_DELETE: begin
                            n_count              = r_count - CW'(1);
                            n_pend.removed_value = $signed(w_last.carry);
                        end
                        olps_pkg::CMD_SEARCH: begin
                            n_pend.found = w_last.hit;
                            if (!w_last.hit) begin
                                n_pend.status = olps_pkg::STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                            if (w_last.hit) begin
                                n_count              = r_count - CW'(1);
                                n_pend.found         = 1'b1;
                                n_pend.removed_value = $signed(w_last.carry);
                            end else begin
                                n_pend.status = olps_pkg::STAT_NOT_FOUND;
                            end
                        end
                    endcase
                    n_pend.entry_count = olps_pkg::COUNT_W'(n_count);
                    n_state            = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state is reset; word registers are not.
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_inj.act   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_inj       <= n_inj;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    // The list never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // An accepted command always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted command did not start");

    // The count only moves when a wave completes.
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |=> $stable(r_count))
        else $error("entry count changed outside a wave");

    // A wave reaches the end of the row only while a command is running.
    a_wave_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.act |-> (r_state == S_RUN))
        else $error("stray wave at end of row");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

    import olps_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_WORDS = 1000;
    localparam int IDLE_LIMIT   = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int TABLE_ROWS   = 26;

    // One row of the directed table; want is only used where typed is set.
    typedef struct {
        logic [CMD_W-1:0] command;
        logic [VAL_W-1:0] value;
        bit               typed;
        t_out_word        want;
    } t_step_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    olps_stream_if #(.t_data(t_in_word))  cmd_if ();
    olps_stream_if #(.t_data(t_out_word)) res_if ();

    // Shadow of the list contents, front first, and the result words still owed.
    logic signed [VAL_W-1:0] held_words[$];
    t_out_word               pending_results[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    bit sender_calm    = 1'b0;
    bit sink_calm      = 1'b0;

    // Directed commands: empty-list cases, the value extremes, filling to capacity,
    // insert when full, and removal of a duplicated value and of the back entry.
    t_step_row step_table [TABLE_ROWS] = '{
        '{CMD_DELETE, 32'h0000_0000, 1'b1, '{STAT_EMPTY, 1'b0, 32'sd0, 5'd0}},
        '{CMD_SEARCH, 32'h7FFF_FFFF, 1'b1, '{STAT_EMPTY, 1'b0, 32'sd0, 5'd0}},
        '{CMD_REMOVE, 32'h8000_0000, 1'b1, '{STAT_EMPTY, 1'b0, 32'sd0, 5'd0}},
        '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, '{STAT_OK, 1'b0, 32'sd0, 5'd1}},
        '{CMD_INSERT, 32'h8000_0000, 1'b1, '{STAT_OK, 1'b0, 32'sd0, 5'd2}},
        '{CMD_SEARCH, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_SEARCH, 32'h0000_0000, 1'b0, '0},
        '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0007, 1'b0, '0},
        '{CMD_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0007, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0000, 1'b0, '0},
        '{CMD_INSERT, 32'h5555_5555, 1'b0, '0},
        '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0007, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0001, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0002, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0003, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0004, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0005, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_0006, 1'b0, '0},
        '{CMD_INSERT, 32'hFFFF_FFF9, 1'b0, '0},
        '{CMD_INSERT, 32'h0000_002A, 1'b1, '{STAT_FULL, 1'b0, 32'sd0, 5'd16}},
        '{CMD_REMOVE, 32'h0000_0007, 1'b0, '0},
        '{CMD_REMOVE, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_DELETE, 32'h0000_0000, 1'b0, '0}
    };

    ordered_list_push_pop_search_remove_unit #(
        .DEPTH (LIST_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Applies one command to the shadow list and returns the word it should produce.
    function automatic t_out_word apply_list_command(input t_in_word w);
        t_out_word r;
        int        hit_at;
        r      = '0;
        r.status = STAT_OK;
        hit_at = -1;
        if (w.command != CMD_INSERT && held_words.size() == 0) begin
            r.status = STAT_EMPTY;
        end else begin
            case (w.command)
                CMD_INSERT: begin
                    if (held_words.size() >= LIST_DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        held_words.push_front(w.value);
                    end
                end
                CMD_DELETE: begin
                    r.removed_value = held_words.pop_front();
                end
                default: begin
                    // Search and remove both look for the frontmost equal entry.
                    foreach (held_words[i]) begin
                        if (hit_at < 0 && held_words[i] == w.value) begin
                            hit_at = i;
                        end
                    end
                    if (hit_at < 0) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        r.found = 1'b1;
                        if (w.command == CMD_REMOVE) begin
                            r.removed_value = held_words[hit_at];
                            held_words.delete(hit_at);
                        end
                    end
                end
            endcase
        end
        r.entry_count = COUNT_W'(held_words.size());
        return r;
    endfunction

    // Offers one command word after a random gap and records its expected result on acceptance.
    task automatic send_command(input t_in_word w, input bit typed, input t_out_word want);
        t_out_word predicted;
        int        gap;
        gap = sender_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= w;
        do @(posedge i_clk); while (!cmd_if.ready);
        predicted = apply_list_command(w);
        pending_results.push_back(typed ? want : predicted);
        if ($urandom_range(0, 29) == 0) begin
            sender_calm = !sender_calm;
        end
    endtask

    // Reset, directed table, random commands, then drain and report.
    initial begin
        t_in_word word_out;
        bit       filling;
        int       pick;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (step_table[i]) begin
            word_out.command = step_table[i].command;
            word_out.value   = step_table[i].value;
            send_command(word_out, step_table[i].typed, step_table[i].want);
        end

        // Random part sweeps the list between empty and full, with values often
        // taken from the list itself or a small pool so that searches and removes hit.
        filling = 1'b1;
        repeat (RANDOM_WORDS) begin
            if ((held_words.size() == LIST_DEPTH && filling && $urandom_range(0, 3) == 0) ||
                (held_words.size() == 0 && !filling && $urandom_range(0, 3) == 0) ||
                $urandom_range(0, 49) == 0) begin
                filling = !filling;
            end
            pick = $urandom_range(0, 99);
            if (filling) begin
                word_out.command = (pick < 55) ? CMD_INSERT :
                                   (pick < 70) ? CMD_DELETE :
                                   (pick < 85) ? CMD_SEARCH : CMD_REMOVE;
            end else begin
                word_out.command = (pick < 15) ? CMD_INSERT :
                                   (pick < 50) ? CMD_DELETE :
                                   (pick < 65) ? CMD_SEARCH : CMD_REMOVE;
            end
            pick = $urandom_range(0, 9);
            if (pick < 4 && held_words.size() != 0) begin
                word_out.value = held_words[$urandom_range(0, held_words.size() - 1)];
            end else if (pick < 7) begin
                word_out.value = VAL_W'($urandom_range(0, 7)) - VAL_W'(4);
            end else begin
                word_out.value = $urandom;
            end
            send_command(word_out, 1'b0, '0);
        end
        cmd_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LIST_DEPTH + 4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: random stalls, then each word is compared with the oldest expectation.
    initial begin
        t_out_word want;
        int        stall;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            if ($urandom_range(0, 29) == 0) begin
                sink_calm = !sink_calm;
            end
            if (pending_results.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("Unexpected word: status %0d found %0d value %0d count %0d",
                             res_if.data.status, res_if.data.found,
                             res_if.data.removed_value, res_if.data.entry_count);
                end
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.data.status != want.status || res_if.data.found != want.found ||
                    res_if.data.removed_value != want.removed_value ||
                    res_if.data.entry_count != want.entry_count) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("Expected status %0d found %0d value %0d count %0d",
                                 want.status, want.found, want.removed_value, want.entry_count);
                        $display("Got      status %0d found %0d value %0d count %0d",
                                 res_if.data.status, res_if.data.found,
                                 res_if.data.removed_value, res_if.data.entry_count);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
